// ===== design/swrms_pkg.sv =====
package swrms_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CH_W = 2;
  localparam int MAX_CH = 4;
  localparam int GAIN_W = 18;
  localparam int RMS_W = 20;
  localparam int SCALED_W = 16;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int SUM_W = 23;
  localparam int SQ_W = 34;
  localparam int VAR_W = 48;
  localparam int RAD_W = 64;
  localparam int ROOT_W = 32;
  localparam int PROD_W = RMS_W + GAIN_W;

  localparam int DEF_WINDOW_DEPTH = 256;
  localparam int DEF_CHANNELS = 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;
  localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

  localparam logic [GAIN_W-1:0] GAIN_RESET [MAX_CH] = '{
    18'd42795, 18'd44499, 18'd74252, 18'd65536
  };

  typedef struct packed {
    logic                       is_tick;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] value;
  } cmd_t;

endpackage

// ===== design/swrms_if.sv =====
interface swrms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [swrms_pkg::CH_W-1:0]            channel;
  logic signed [swrms_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, command, channel, sample_value, input ready);
  modport sink (input valid, command, channel, sample_value, output ready);
endinterface

interface swrms_out_if;
  logic                             valid;
  logic                             ready;
  logic [swrms_pkg::CH_W-1:0]       out_channel;
  logic [swrms_pkg::RMS_W-1:0]      rms_q8;
  logic [swrms_pkg::SCALED_W-1:0]   scaled_rms;
  logic                             last;

  modport source (output valid, out_channel, rms_q8, scaled_rms, last, input ready);
  modport sink (input valid, out_channel, rms_q8, scaled_rms, last, output ready);
endinterface

// ===== design/swrms_front.sv =====
module swrms_front #(
  parameter int CHANNELS = swrms_pkg::DEF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  swrms_in_if.sink           in_chan,
  output swrms_pkg::cmd_t    head,
  output logic               head_valid,
  input  logic               pop
);

  swrms_pkg::cmd_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            accept;
  logic            keep;
  logic            push;
  logic            take;

  assign in_chan.ready = (count_r != 2'd2);
  assign accept = in_chan.valid && in_chan.ready;
  // samples for absent channels are dropped here
  assign keep = (in_chan.command == swrms_pkg::CMD_TICK) ||
                (32'(in_chan.channel) < CHANNELS);
  assign push = accept && keep;
  assign head_valid = (count_r != 2'd0);
  assign head = q_r[rd_ptr_r];
  assign take = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{is_tick: in_chan.command, ch: in_chan.channel,
                         value: in_chan.sample_value};
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (take) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(take);
    end
  end

endmodule

// ===== design/swrms_back.sv =====
module swrms_back #(
  parameter int WINDOW_DEPTH = swrms_pkg::DEF_WINDOW_DEPTH,
  parameter int CHANNELS = swrms_pkg::DEF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swrms_pkg::cmd_t                head,
  input  logic                           head_valid,
  output logic                           pop,
  input  logic [swrms_pkg::GAIN_W-1:0]   gain [swrms_pkg::MAX_CH],
  swrms_out_if.source                    out_chan
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CHI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_D = 1 << (CHI_W + PTR_W);
  localparam int SW = swrms_pkg::SAMPLE_W;
  localparam int SQS_W = 2 * SW;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_UPD  = 9'b000000100,
    T_MUL  = 9'b000001000,
    T_SUB  = 9'b000010000,
    T_SQRT = 9'b000100000,
    T_DIV  = 9'b001000000,
    T_GAIN = 9'b010000000,
    T_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SW-1:0]                   mem [MEM_D];
  logic [PTR_W-1:0]                       wp_r [CHANNELS];
  logic [CNT_W-1:0]                       fill_r [CHANNELS];
  logic signed [swrms_pkg::SUM_W-1:0]     sum_r [CHANNELS];
  logic [swrms_pkg::SQ_W-1:0]             sq_r [CHANNELS];

  swrms_pkg::cmd_t                        cur_r;
  logic signed [SW-1:0]                   old_r;
  logic [SQS_W-1:0]                       vsq_r;
  logic [CHI_W-1:0]                       tc_r;
  logic [swrms_pkg::VAR_W-1:0]            nsq_r;
  logic [swrms_pkg::VAR_W-1:0]            ss_r;
  logic [swrms_pkg::RAD_W-1:0]            rad_r;
  logic [swrms_pkg::RAD_W-1:0]            root_r;
  logic [swrms_pkg::RAD_W-1:0]            bit_r;
  logic [4:0]                             it_r;
  logic [swrms_pkg::ROOT_W-1:0]           dq_r;
  logic [CNT_W-1:0]                       rem_r;
  logic [swrms_pkg::RMS_W-1:0]            rms_r;
  logic [swrms_pkg::PROD_W-1:0]           prod_r;

  logic                                   out_valid_r;
  logic [swrms_pkg::CH_W-1:0]             out_ch_r;
  logic [swrms_pkg::RMS_W-1:0]            out_rms_r;
  logic [swrms_pkg::SCALED_W-1:0]         out_scaled_r;
  logic                                   out_last_r;

  logic [CHI_W-1:0]                       chi;
  logic [CHI_W+PTR_W-1:0]                 addr;
  logic                                   full;
  logic [SQS_W-1:0]                       old_sq;
  logic signed [swrms_pkg::VAR_W:0]       diff;
  logic [swrms_pkg::RAD_W-1:0]            trial;
  logic [CNT_W:0]                         rem_sh;
  logic                                   q_bit;
  logic [swrms_pkg::PROD_W:0]             rounded;
  logic                                   slot_free;
  logic                                   is_last;

  assign chi = cur_r.ch[CHI_W-1:0];
  assign addr = {chi, wp_r[chi]};
  assign full = (fill_r[chi] == CNT_W'(WINDOW_DEPTH));
  assign old_sq = SQS_W'(old_r * old_r);
  assign diff = $signed({1'b0, nsq_r}) - $signed({1'b0, ss_r});
  assign trial = root_r + bit_r;
  assign rem_sh = {rem_r, dq_r[swrms_pkg::ROOT_W-1]};
  assign q_bit = (rem_sh >= {1'b0, fill_r[tc_r]});
  assign rounded = {1'b0, prod_r} + (swrms_pkg::PROD_W+1)'(1 << 23);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign is_last = (tc_r == CHI_W'(CHANNELS - 1));
  assign pop = (state_r == S_IDLE) && head_valid;

  assign out_chan.valid = out_valid_r;
  assign out_chan.out_channel = out_ch_r;
  assign out_chan.rms_q8 = out_rms_r;
  assign out_chan.scaled_rms = out_scaled_r;
  assign out_chan.last = out_last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (head_valid) state_nxt = head.is_tick ? T_MUL : S_RD;
      end
      S_RD:   state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      T_MUL:  state_nxt = (fill_r[tc_r] == '0) ? T_GAIN : T_SUB;
      T_SUB:  state_nxt = T_SQRT;
      T_SQRT: if (it_r == 5'd31) state_nxt = T_DIV;
      T_DIV:  if (it_r == 5'd31) state_nxt = T_GAIN;
      T_GAIN: state_nxt = T_OUT;
      T_OUT: begin
        if (slot_free) state_nxt = is_last ? S_IDLE : T_MUL;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (head_valid) cur_r <= head;
        tc_r <= '0;
      end
      S_RD: begin
        old_r <= mem[addr];
        vsq_r <= SQS_W'(cur_r.value * cur_r.value);
      end
      S_UPD: begin
        mem[addr] <= cur_r.value;
      end
      T_MUL: begin
        nsq_r <= swrms_pkg::VAR_W'(fill_r[tc_r]) * swrms_pkg::VAR_W'(sq_r[tc_r]);
        ss_r <= swrms_pkg::VAR_W'(sum_r[tc_r] * sum_r[tc_r]);
        rms_r <= '0;
      end
      T_SUB: begin
        rad_r <= diff[swrms_pkg::VAR_W] ? '0 : {diff[swrms_pkg::VAR_W-1:0], 16'd0};
        root_r <= '0;
        bit_r <= swrms_pkg::RAD_W'(1) << 62;
        it_r <= '0;
      end
      T_SQRT: begin
        if (rad_r >= trial) begin
          rad_r <= rad_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r <= it_r + 5'd1;
        if (it_r == 5'd31) begin
          dq_r <= swrms_pkg::ROOT_W'((root_r >> 1) + ((rad_r >= trial) ? bit_r : '0));
          rem_r <= '0;
        end
      end
      T_DIV: begin
        rem_r <= q_bit ? CNT_W'(rem_sh - {1'b0, fill_r[tc_r]}) : rem_sh[CNT_W-1:0];
        dq_r <= {dq_r[swrms_pkg::ROOT_W-2:0], q_bit};
        it_r <= it_r + 5'd1;
        if (it_r == 5'd31) begin
          rms_r <= (|dq_r[swrms_pkg::ROOT_W-2:swrms_pkg::RMS_W-1]) ? swrms_pkg::RMS_MAX
                   : {dq_r[swrms_pkg::RMS_W-2:0], q_bit};
        end
      end
      T_GAIN: begin
        prod_r <= swrms_pkg::PROD_W'(rms_r) * swrms_pkg::PROD_W'(gain[swrms_pkg::CH_W'(tc_r)]);
      end
      T_OUT: begin
        if (slot_free) begin
          out_ch_r <= swrms_pkg::CH_W'(tc_r);
          out_rms_r <= rms_r;
          out_scaled_r <= swrms_pkg::SCALED_W'(rounded[swrms_pkg::PROD_W:24]);
          out_last_r <= is_last;
          tc_r <= tc_r + CHI_W'(1);
        end
      end
      default: ;
    endcase

    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c] <= '0;
        fill_r[c] <= '0;
        sum_r[c] <= '0;
        sq_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == T_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        if (full) begin
          sum_r[chi] <= sum_r[chi] - swrms_pkg::SUM_W'(old_r)
                        + swrms_pkg::SUM_W'(cur_r.value);
          sq_r[chi] <= sq_r[chi] - swrms_pkg::SQ_W'(old_sq) + swrms_pkg::SQ_W'(vsq_r);
        end else begin
          fill_r[chi] <= fill_r[chi] + CNT_W'(1);
          sum_r[chi] <= sum_r[chi] + swrms_pkg::SUM_W'(cur_r.value);
          sq_r[chi] <= sq_r[chi] + swrms_pkg::SQ_W'(vsq_r);
        end
        wp_r[chi] <= (32'(wp_r[chi]) + 1 >= WINDOW_DEPTH) ? '0 : wp_r[chi] + PTR_W'(1);
      end
    end
  end

endmodule

// ===== design/sliding_window_ac_rms.sv =====
// sample beat: in the back end, taken in idle, then ring read, then ring write with update; one at a time
// tick beat: per channel multiply, subtract, 32 square-root steps, 32 divide steps, gain, out
// an empty channel goes multiply, gain, out; a stalled sink holds the out step
// the iterative square-root and divide steps set the tick time; a 2-entry queue decouples input
// reset (synchronous, rst_n low) clears fill counts, pointers, sums, queue and gains to defaults
module sliding_window_ac_rms #(
  parameter int WINDOW_DEPTH = swrms_pkg::DEF_WINDOW_DEPTH,
  parameter int CHANNELS = swrms_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  swrms_in_if.sink                        in_chan,
  swrms_out_if.source                     out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swrms_pkg::CFG_AW-1:0]    paddr,
  input  logic [swrms_pkg::CFG_DW-1:0]    pwdata,
  output logic [swrms_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready
);

  logic [swrms_pkg::GAIN_W-1:0] gain_r [swrms_pkg::MAX_CH];
  swrms_pkg::cmd_t              head;
  logic                         head_valid;
  logic                         pop;
  logic [1:0]                   reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;
  assign prdata = swrms_pkg::CFG_DW'(gain_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= swrms_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite) begin
      gain_r[reg_idx] <= pwdata[swrms_pkg::GAIN_W-1:0];
    end
  end

  swrms_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan),
    .head(head), .head_valid(head_valid), .pop(pop)
  );

  swrms_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .CHANNELS(CHANNELS)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .head_valid(head_valid), .pop(pop),
    .gain(gain_r), .out_chan(out_chan)
  );

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");
  a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last |-> 32'(out_chan.out_channel) == CHANNELS - 1)
    else $error("last flag on wrong channel");
  a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.rms_q8 == '0 |-> out_chan.scaled_rms == '0)
    else $error("scaled value without rms");

endmodule

// ===== tb/swrms_tb_if.sv =====
`timescale 1ns / 100ps
interface swrms_cfg_bus;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [swrms_pkg::CFG_AW-1:0] paddr;
  logic [swrms_pkg::CFG_DW-1:0] pwdata;
  logic [swrms_pkg::CFG_DW-1:0] prdata;
  logic                         pready;
endinterface

// ===== tb/sliding_window_ac_rms_tb.sv =====
`timescale 1ns / 100ps
module sliding_window_ac_rms_tb;

  localparam int DEPTH = swrms_pkg::DEF_WINDOW_DEPTH;
  localparam int NCH = swrms_pkg::DEF_CHANNELS;

  typedef struct packed {
    logic [swrms_pkg::CH_W-1:0]     ch;
    logic [swrms_pkg::RMS_W-1:0]    rms;
    logic [swrms_pkg::SCALED_W-1:0] scaled;
    logic                           last;
  } rms_res_t;

  typedef struct {
    swrms_pkg::cmd_t cmd;
    logic            has_exp;
    rms_res_t        exp0;
  } dir_row_t;

  logic clk;
  logic rst_n;
  swrms_in_if in_chan ();
  swrms_out_if out_chan ();
  swrms_cfg_bus cfg ();

  sliding_window_ac_rms u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(cfg.psel), .penable(cfg.penable), .pwrite(cfg.pwrite), .paddr(cfg.paddr),
    .pwdata(cfg.pwdata), .prdata(cfg.prdata), .pready(cfg.pready)
  );

  logic signed [swrms_pkg::SAMPLE_W-1:0] ring [NCH][DEPTH];
  int unsigned wr_ptr [NCH];
  int unsigned fill [NCH];
  longint acc_sum [NCH];
  longint acc_sq [NCH];
  logic [swrms_pkg::GAIN_W-1:0] gain [swrms_pkg::MAX_CH];

  rms_res_t pending_rms [$];
  int errors;
  bit quiet;
  bit long_stall;
  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("sliding_window_ac_rms_tb: FAIL");
    $finish;
  end

  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic window_update(input swrms_pkg::cmd_t c);
    rms_res_t r;
    longint n, t;
    longint unsigned rms, sc;
    logic signed [swrms_pkg::SAMPLE_W-1:0] old;
    if (c.is_tick == swrms_pkg::CMD_SAMPLE) begin
      if (c.ch >= NCH) return;
      if (fill[c.ch] >= DEPTH) begin
        old = ring[c.ch][wr_ptr[c.ch]];
        acc_sum[c.ch] -= old;
        acc_sq[c.ch] -= longint'(old) * old;
      end else begin
        fill[c.ch]++;
      end
      ring[c.ch][wr_ptr[c.ch]] = c.value;
      acc_sum[c.ch] += c.value;
      acc_sq[c.ch] += longint'(c.value) * c.value;
      wr_ptr[c.ch] = (wr_ptr[c.ch] + 1 >= DEPTH) ? 0 : wr_ptr[c.ch] + 1;
    end else begin
      for (int i = 0; i < NCH; i++) begin
        rms = 0;
        sc = 0;
        n = fill[i];
        if (n > 0) begin
          t = n * acc_sq[i] - acc_sum[i] * acc_sum[i];
          if (t < 0) t = 0;
          rms = root_of(longint'(t) << 16) / n;
          if (rms > swrms_pkg::RMS_MAX) rms = swrms_pkg::RMS_MAX;
          sc = (rms * gain[i] + (64'd1 << 23)) >> 24;
          if (sc > swrms_pkg::SCALED_MAX) sc = swrms_pkg::SCALED_MAX;
        end
        r.ch = swrms_pkg::CH_W'(i);
        r.rms = swrms_pkg::RMS_W'(rms);
        r.scaled = swrms_pkg::SCALED_W'(sc);
        r.last = (i == NCH - 1);
        pending_rms.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic cfg_write(input int idx, input logic [31:0] val);
    cfg.psel <= 1'b1;
    cfg.pwrite <= 1'b1;
    cfg.paddr <= swrms_pkg::CFG_AW'(idx * 4);
    cfg.pwdata <= val;
    @(posedge clk);
    cfg.penable <= 1'b1;
    @(posedge clk);
    while (!cfg.pready) @(posedge clk);
    cfg.psel <= 1'b0;
    cfg.penable <= 1'b0;
    cfg.pwrite <= 1'b0;
    if (idx < swrms_pkg::MAX_CH) gain[idx] = val[swrms_pkg::GAIN_W-1:0];
    @(posedge clk);
    if (cfg.prdata !== swrms_pkg::CFG_DW'(val[swrms_pkg::GAIN_W-1:0]))
      report_mismatch("readback", cfg.prdata, val[swrms_pkg::GAIN_W-1:0]);
  endtask

  task automatic send_beat(input swrms_pkg::cmd_t c);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= c.is_tick;
    in_chan.channel <= c.ch;
    in_chan.sample_value <= c.value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    window_update(c);
  endtask

  task automatic go_idle();
    in_chan.valid <= 1'b0;
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic swrms_pkg::cmd_t rand_cmd(input int tick_pct);
    swrms_pkg::cmd_t c;
    int m;
    c.is_tick = ($urandom_range(0, 99) < tick_pct) ? swrms_pkg::CMD_TICK : swrms_pkg::CMD_SAMPLE;
    c.ch = swrms_pkg::CH_W'($urandom_range(0, 3));
    m = $urandom_range(0, 5);
    if (m == 0) c.value = swrms_pkg::SAMPLE_W'($urandom);
    else if (m == 1) c.value = $urandom_range(0, 1) ? 12'sh7ff : 12'sh800;
    else c.value = 12'(int'($urandom_range(0, 200)) - 100 + 500);
    return c;
  endfunction

  task automatic run_random(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) send_beat(rand_cmd(tick_pct));
  endtask

  always @(posedge clk) begin
    rms_res_t w;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_rms.size() == 0) begin
        report_mismatch("unexpected beat", out_chan.out_channel, -1);
      end else begin
        w = pending_rms.pop_front();
        if (out_chan.out_channel !== w.ch) report_mismatch("channel", out_chan.out_channel, w.ch);
        if (out_chan.rms_q8 !== w.rms) report_mismatch("rms_q8", out_chan.rms_q8, w.rms);
        if (out_chan.scaled_rms !== w.scaled)
          report_mismatch("scaled_rms", out_chan.scaled_rms, w.scaled);
        if (out_chan.last !== w.last) report_mismatch("last", out_chan.last, w.last);
      end
    end
  end

  initial begin
    int gap;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_stall) begin
        out_chan.ready <= 1'b0;
        repeat (2000) @(posedge clk);
        long_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        gap = $urandom_range(1, 15);
        repeat (gap) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    swrms_pkg::cmd_t c;
    dir_row_t d;
    rms_res_t z;
    logic [11:0] walk;
    errors = 0;
    quiet = 1'b0;
    long_stall = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.command = swrms_pkg::CMD_SAMPLE;
    in_chan.channel = '0;
    in_chan.sample_value = '0;
    cfg.psel = 1'b0;
    cfg.penable = 1'b0;
    cfg.pwrite = 1'b0;
    cfg.paddr = '0;
    cfg.pwdata = '0;
    for (int i = 0; i < NCH; i++) begin
      wr_ptr[i] = 0;
      fill[i] = 0;
      acc_sum[i] = 0;
      acc_sq[i] = 0;
    end
    for (int i = 0; i < swrms_pkg::MAX_CH; i++) gain[i] = swrms_pkg::GAIN_RESET[i];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: empty tick first, then extremes and absent channel
    z = '0;
    d.has_exp = 1'b1; d.exp0 = z;
    d.cmd = '{swrms_pkg::CMD_TICK, 2'd0, 12'sd0}; dir_rows.push_back(d);
    d.has_exp = 1'b0;
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd0, 12'sh7ff}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd0, 12'sh800}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd1, 12'sh555}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd1, 12'shaaa}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd2, 12'sd0}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd3, 12'sh7ff}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd3, 12'sh800}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_TICK, 2'd3, 12'shfff}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_SAMPLE, 2'd2, 12'sh7ff}; dir_rows.push_back(d);
    d.cmd = '{swrms_pkg::CMD_TICK, 2'd1, 12'sh123}; dir_rows.push_back(d);
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].cmd);
      // typed-in check: the first result of the empty tick (channel 0) reports zero
      if (dir_rows[i].has_exp && pending_rms.size() > 0 && pending_rms[0] != dir_rows[i].exp0)
        report_mismatch("directed row", pending_rms[0].rms, dir_rows[i].exp0.rms);
    end
    go_idle();

    // gain extremes, every register
    cfg_write(0, 32'h3ffff);
    cfg_write(1, 32'h0);
    cfg_write(2, 32'h3ffff);
    cfg_write(3, 32'h12345);
    send_beat('{swrms_pkg::CMD_TICK, 2'd0, 12'sd0});
    go_idle();

    // fill channel 0 past the window to exercise eviction
    for (int i = 0; i < DEPTH + 20; i++) begin
      walk = 12'($urandom);
      c = '{swrms_pkg::CMD_SAMPLE, 2'd0, walk};
      if (i % 64 == 63) c.is_tick = swrms_pkg::CMD_TICK;
      send_beat(c);
    end
    go_idle();

    cfg_write(0, $urandom_range(0, 262143));
    cfg_write(1, $urandom_range(0, 262143));
    cfg_write(2, $urandom_range(0, 262143));
    cfg_write(3, $urandom_range(0, 262143));

    run_random(30, 12);

    // output held off while ticks pile up
    long_stall = 1'b1;
    for (int i = 0; i < 8; i++) send_beat('{swrms_pkg::CMD_TICK, 2'd0, 12'sd0});
    // sender waits for all results
    go_idle();

    cfg_write(0, 32'h0);
    cfg_write(1, 32'h3ffff);
    cfg_write(2, 32'h10000);
    cfg_write(3, 32'h0);
    run_random(20, 10);
    go_idle();

    cfg_write(0, 32'(swrms_pkg::GAIN_RESET[0]));
    cfg_write(1, 32'(swrms_pkg::GAIN_RESET[1]));
    cfg_write(2, 32'(swrms_pkg::GAIN_RESET[2]));
    quiet = 1'b1;
    run_random(20, 10);
    send_beat('{swrms_pkg::CMD_TICK, 2'd0, 12'sd0});
    in_chan.valid <= 1'b0;
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("sliding_window_ac_rms_tb: PASS");
    end else begin
      $display("sliding_window_ac_rms_tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/swrms_pkg.sv
design/swrms_if.sv
design/swrms_front.sv
design/swrms_back.sv
design/sliding_window_ac_rms.sv
tb/swrms_tb_if.sv
tb/sliding_window_ac_rms_tb.sv
